@@ rtl/core/tte_pkg.sv @@
`default_nettype none
package tte_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ID_W    = 31;
    localparam int DATA_W  = 32;
    localparam int REQ_W   = 3;
    localparam int CNT_W   = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 3'd0,
        REQ_GET    = 3'd1,
        REQ_DEL    = 3'd2,
        REQ_OWNER  = 3'd3,
        REQ_TICK   = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        RES_ADD    = 3'd0,
        RES_GET    = 3'd1,
        RES_DEL    = 3'd2,
        RES_OWNER  = 3'd3,
        RES_EXPIRY = 3'd4,
        RES_DONE   = 3'd5
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_EMIT,
        ST_FINISH
    } state_t;

    // Packed table entry held in the memory.
    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [DATA_W-1:0] deadline;
        logic [DATA_W-1:0] owner;
        logic [DATA_W-1:0] code;
    } entry_t;

endpackage
`default_nettype wire

@@ rtl/core/tte_mem.sv @@
`default_nettype none
module tte_mem
    import tte_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = 5
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);
    entry_t mem [DEPTH];
    entry_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;
endmodule
`default_nettype wire

@@ rtl/core/timer_table_engine.sv @@
// An add answers in the cycle after its transaction is accepted. Get, delete,
// delete-by-owner and tick read each occupied entry (ST_READ), evaluate and compact
// it (ST_EVAL), then close via ST_READ and ST_FINISH; a get stops at its matching entry.
// Each expiry passes ST_EMIT and holds the scan until the previous result is taken.
// One request in work at a time; the next is taken once the final result is accepted.
// Reset (aresetn low, synchronous) empties table, clears time, next id one; memory kept.
`default_nettype none
module timer_table_engine
    import tte_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [REQ_W-1:0]    s_req_type,
    input  wire logic [ID_W-1:0]     s_timer_ident,
    input  wire logic [DATA_W-1:0]   s_owner_ident,
    input  wire logic [DATA_W-1:0]   s_event_code,
    input  wire logic                s_any_code,
    input  wire logic [DATA_W-1:0]   s_delay_ticks,
    input  wire logic [DATA_W-1:0]   s_elapsed_ticks,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [2:0]               m_result_kind,
    output logic [ID_W-1:0]          m_out_timer_ident,
    output logic [DATA_W-1:0]        m_out_owner_ident,
    output logic [DATA_W-1:0]        m_out_event_code,
    output logic signed [DATA_W-1:0] m_remaining_ticks,
    output logic                     m_found_flag,
    output logic [CNT_W-1:0]         m_removed_count,
    output logic                     m_table_full,
    output logic                     m_last_of_run
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;     // occupied entries
    logic [DATA_W-1:0]  now_reg, now_next;
    logic [ID_W-1:0]    nid_reg, nid_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;   // next entry to read
    logic [CNT_W-1:0]   wr_idx_reg, wr_idx_next;   // compaction write pointer
    logic [CNT_W-1:0]   rm_reg, rm_next;           // entries removed so far
    logic               hit_reg, hit_next;         // delete already hit once
    logic               mvalid_reg, mvalid_next;

    // Request payload held for the scan
    req_t               req_reg;
    logic [ID_W-1:0]    tid_reg;
    logic [DATA_W-1:0]  own_reg, code_reg;
    logic               any_reg;

    // Result registers
    logic [2:0]         kind_reg, kind_next;
    logic [ID_W-1:0]    oid_reg, oid_next;
    logic [DATA_W-1:0]  oown_reg, oown_next, ocode_reg, ocode_next;
    logic [DATA_W-1:0]  rem_reg, rem_next;
    logic               found_reg, found_next, full_reg, full_next, last_reg, last_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    entry_t             wr_data, rd_data;
    logic               drop;

    tte_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign rd_addr = rd_idx_reg[AW-1:0];

    // Decide whether the entry just read leaves the table
    always_comb begin
        drop = 1'b0;
        unique case (req_reg)
            REQ_DEL:   drop = !hit_reg && (rd_data.ident == tid_reg);
            REQ_OWNER: drop = (rd_data.owner == own_reg) &&
                              (any_reg || rd_data.code == code_reg);
            REQ_TICK:  drop = (rd_data.deadline <= now_reg);
            default:   drop = 1'b0;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        now_next    = now_reg;
        nid_next    = nid_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        rm_next     = rm_reg;
        hit_next    = hit_reg;
        mvalid_next = mvalid_reg;
        kind_next   = kind_reg;
        oid_next    = oid_reg;
        oown_next   = oown_reg;
        ocode_next  = ocode_reg;
        rem_next    = rem_reg;
        found_next  = found_reg;
        full_next   = full_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        wr_en       = 1'b0;
        wr_addr     = wr_idx_reg[AW-1:0];
        wr_data     = rd_data;

        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    rm_next     = '0;
                    hit_next    = 1'b0;
                    kind_next   = s_req_type;
                    oid_next    = '0;
                    oown_next   = '0;
                    ocode_next  = '0;
                    rem_next    = '0;
                    found_next  = 1'b0;
                    full_next   = 1'b0;
                    cnt_next    = '0;
                    last_next   = 1'b1;
                    priority case (s_req_type)
                        REQ_ADD: begin
                            if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
                                full_next = 1'b1;
                            end else begin
                                wr_en         = 1'b1;
                                wr_addr       = count_reg[AW-1:0];
                                wr_data.ident    = nid_reg;
                                wr_data.deadline = now_reg + s_delay_ticks;
                                wr_data.owner    = s_owner_ident;
                                wr_data.code     = s_event_code;
                                count_next    = count_reg + 1'b1;
                                oid_next      = nid_reg;
                                nid_next      = nid_reg + ID_W'(2);
                            end
                            mvalid_next = 1'b1;
                        end
                        REQ_GET, REQ_DEL, REQ_OWNER: begin
                            rem_next   = '1;
                            state_next = ST_READ;
                        end
                        REQ_TICK: begin
                            now_next   = now_reg + s_elapsed_ticks;
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                    if (s_req_type != REQ_GET) begin
                        rem_next = (s_req_type == REQ_ADD) ? '0 : '0;
                    end
                end
            end
            ST_READ: begin
                // Issue read for rd_idx; end of table closes the request
                if (rd_idx_reg >= count_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (req_reg == REQ_TICK && drop && mvalid_reg) begin
                    // Hold this expiry until the previous transaction has left
                    state_next = ST_EVAL;
                end else begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    if (req_reg == REQ_GET) begin
                        if (rd_data.ident == tid_reg) begin
                            rem_next   = rd_data.deadline - now_reg;
                            found_next = 1'b1;
                            state_next = ST_FINISH;
                        end else begin
                            state_next = ST_READ;
                        end
                    end else if (drop) begin
                        rm_next  = rm_reg + 1'b1;
                        hit_next = 1'b1;
                        if (req_reg == REQ_TICK) begin
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_READ;
                        end
                    end else begin
                        // Keep: compact down to the write pointer
                        wr_en       = 1'b1;
                        wr_idx_next = wr_idx_reg + 1'b1;
                        state_next  = ST_READ;
                    end
                    if (req_reg == REQ_TICK && drop) begin
                        kind_next  = RES_EXPIRY;
                        oid_next   = rd_data.ident;
                        oown_next  = rd_data.owner;
                        ocode_next = rd_data.code;
                        last_next  = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                if (!mvalid_reg) begin
                    mvalid_next = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_FINISH: begin
                if (!mvalid_reg) begin
                    count_next  = count_reg - rm_reg;
                    kind_next   = (req_reg == REQ_TICK) ? RES_DONE : req_reg;
                    oid_next    = '0;
                    oown_next   = '0;
                    ocode_next  = '0;
                    last_next   = 1'b1;
                    if (req_reg == REQ_DEL) begin
                        found_next = hit_reg;
                    end
                    if (req_reg == REQ_OWNER) begin
                        cnt_next = rm_reg;
                    end
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            now_reg    <= '0;
            nid_reg    <= ID_W'(1);
            mvalid_reg <= 1'b0;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            rm_reg     <= '0;
            hit_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            now_reg    <= now_next;
            nid_reg    <= nid_next;
            mvalid_reg <= mvalid_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            rm_reg     <= rm_next;
            hit_reg    <= hit_next;
        end
    end

    // Payload and result registers: no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg  <= req_t'(s_req_type);
            tid_reg  <= s_timer_ident;
            own_reg  <= s_owner_ident;
            code_reg <= s_event_code;
            any_reg  <= s_any_code;
        end
        kind_reg  <= kind_next;
        oid_reg   <= oid_next;
        oown_reg  <= oown_next;
        ocode_reg <= ocode_next;
        rem_reg   <= rem_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        last_reg  <= last_next;
        cnt_reg   <= cnt_next;
    end

    assign m_valid           = mvalid_reg;
    assign m_result_kind     = kind_reg;
    assign m_out_timer_ident = oid_reg;
    assign m_out_owner_ident = oown_reg;
    assign m_out_event_code  = ocode_reg;
    assign m_remaining_ticks = rem_reg;
    assign m_found_flag      = found_reg;
    assign m_removed_count   = cnt_reg;
    assign m_table_full      = full_reg;
    assign m_last_of_run     = last_reg;
endmodule
`default_nettype wire

@@ rtl/core/tte_checker.sv @@
`default_nettype none
module tte_checker
    import tte_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_result_kind,
    input wire logic       m_last_of_run,
    input wire logic       m_table_full
);
    // An expiry is never the closing item; every other kind closes
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_of_run == (m_result_kind != RES_EXPIRY)))
        else $error("last_of_run disagrees with result kind");

    // Full flag only on add acks
    a_full_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_table_full) |-> (m_result_kind == RES_ADD))
        else $error("table_full outside add ack");

    // A pending result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before acceptance");

    // No new request is taken while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(s_valid && s_ready))
        else $error("request accepted with result pending");
endmodule

bind timer_table_engine tte_checker u_tte_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_last_of_run (m_last_of_run),
    .m_table_full  (m_table_full)
);
`default_nettype wire
